@@ rtl/core/tasc_pkg.sv @@
// ----------------------------------------------------------------------------
// tasc_pkg: shared types and constants of the tick accumulating system clock
// Beat layouts for both channels, item kind codes and register indexes.
// ----------------------------------------------------------------------------
package tasc_pkg;

	localparam int TIME_W   = 63;
	localparam int COUNT_W  = 64;
	localparam int INC_W    = 31;
	localparam int BUDGET_W = 32;
	localparam int KIND_W   = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [INC_W-1:0] RESET_PERIOD = INC_W'(100000);

	// Item kinds. Any other code behaves as a read.
	localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SET  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_INCREMENT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_ADJUSTMENT = 2'd1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [INC_W-1:0]  increment;
		logic [TIME_W-1:0] new_time;
	} in_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]         system_time;
		logic [TIME_W-1:0]         old_time;
		logic [TIME_W-1:0]         interrupt_time;
		logic [COUNT_W-1:0]        tick_count;
		logic signed [COUNT_W-1:0] boot_time;
		logic                      tick_elapsed;
	} out_item_t;

	typedef struct packed {
		logic                 wr_en;
		logic [CFG_IDX_W-1:0] wr_index;
		logic [INC_W-1:0]     wr_data;
	} cfg_write_t;

endpackage

@@ rtl/core/tasc_in_stage.sv @@
// ----------------------------------------------------------------------------
// tasc_in_stage: input register of the timekeeper
// Holds one accepted beat until the datapath consumes it.
// ----------------------------------------------------------------------------
module tasc_in_stage import tasc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     advance,
	output logic     valid_s1,
	output in_item_t item_s1
);

	logic take;

	// The register frees up in the same cycle that its item moves on.
	assign in_stall = valid_s1 & ~advance;
	assign take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_data;
		end
	end

endmodule

@@ rtl/core/tasc_state.sv @@
// ----------------------------------------------------------------------------
// tasc_state: clock state, configuration registers and update datapath
// Computes the result of one item and commits the new state with it.
// ----------------------------------------------------------------------------
module tasc_state import tasc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_write_t cfg,
	input  logic       fire,
	input  in_item_t   item,
	output out_item_t  result
);

	logic [INC_W-1:0]    max_inc_q;
	logic [INC_W-1:0]    time_adj_q;
	logic [TIME_W-1:0]   irq_clk_q;
	logic [TIME_W-1:0]   wall_q;
	logic [BUDGET_W-1:0] budget_q;
	logic [COUNT_W-1:0]  ticks_q;
	logic [COUNT_W-1:0]  boot_q;

	logic                is_tick;
	logic                is_set;
	logic                elapsed;
	logic [BUDGET_W-1:0] inc_ext;
	logic [BUDGET_W-1:0] budget_dec;
	logic [BUDGET_W-1:0] budget_nxt;
	logic [TIME_W-1:0]   irq_nxt;
	logic [TIME_W-1:0]   wall_nxt;
	logic [COUNT_W-1:0]  ticks_nxt;
	logic [COUNT_W-1:0]  boot_nxt;

	always_comb begin
		is_tick    = (item.kind == KIND_TICK);
		is_set     = (item.kind == KIND_SET);
		inc_ext    = {1'b0, item.increment};
		// Boundary test is a signed compare of the budget held before the tick.
		elapsed    = is_tick && ($signed(budget_q) <= $signed(inc_ext));
		budget_dec = budget_q - inc_ext;
		// Only tick items touch the budget.
		budget_nxt = is_tick ? budget_dec : budget_q;
		if (elapsed) begin
			budget_nxt = budget_dec + {1'b0, max_inc_q};
		end
		irq_nxt    = is_tick ? irq_clk_q + TIME_W'(item.increment) : irq_clk_q;
		ticks_nxt  = elapsed ? ticks_q + COUNT_W'(1) : ticks_q;
		if (is_set) begin
			wall_nxt = item.new_time;
		end else if (elapsed) begin
			wall_nxt = wall_q + TIME_W'(time_adj_q);
		end else begin
			wall_nxt = wall_q;
		end
		boot_nxt = is_set ? boot_q + {1'b0, item.new_time} - {1'b0, wall_q} : boot_q;

		result.system_time    = wall_nxt;
		result.old_time       = wall_q;
		result.interrupt_time = irq_nxt;
		result.tick_count     = ticks_nxt;
		result.boot_time      = boot_nxt;
		result.tick_elapsed   = elapsed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_inc_q  <= RESET_PERIOD;
			time_adj_q <= RESET_PERIOD;
			irq_clk_q  <= '0;
			wall_q     <= '0;
			budget_q   <= BUDGET_W'(RESET_PERIOD);
			ticks_q    <= '0;
			boot_q     <= '0;
		end else begin
			if (fire) begin
				irq_clk_q <= irq_nxt;
				wall_q    <= wall_nxt;
				budget_q  <= budget_nxt;
				ticks_q   <= ticks_nxt;
				boot_q    <= boot_nxt;
			end
			// Writing the period also reloads the budget.
			if (cfg.wr_en && cfg.wr_index == CFG_MAX_INCREMENT) begin
				max_inc_q <= cfg.wr_data;
				budget_q  <= {1'b0, cfg.wr_data};
			end
			if (cfg.wr_en && cfg.wr_index == CFG_TIME_ADJUSTMENT) begin
				time_adj_q <= cfg.wr_data;
			end
		end
	end

endmodule

@@ rtl/core/tasc_out_stage.sv @@
// ----------------------------------------------------------------------------
// tasc_out_stage: result register of the timekeeper
// Holds a finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module tasc_out_stage import tasc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  out_item_t result,
	output logic      can_load,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	// The register can take a new result when empty or when its beat leaves now.
	assign can_load = ~out_valid | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data <= result;
		end
	end

endmodule

@@ rtl/core/tick_accumulating_system_clock_core.sv @@
// ----------------------------------------------------------------------------
// tick_accumulating_system_clock_core: tick accumulating timekeeper
// Keeps interrupt time, system time, boot time and a full tick count.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the in channel (in_valid, in_stall, in_data) and
// each one produces exactly one result beat on the out channel (out_valid,
// out_stall, out_data). A tick item advances interrupt time and the tick
// budget; a set item replaces system time and shifts boot time; a read
// item only reports. Every result also returns system time before the item.
// Flow: a beat accepted at a clock edge is registered in the input stage,
// and its result is loaded into the output register, which raises
// out_valid, once that register can take it.
// Throughput: one item per cycle while out_stall is low. The clock state
// is updated in the same cycle as its result, so back-to-back ticks see each other.
// Stalls: when the receiver holds out_stall, the output register keeps its
// beat, one more item waits in the input stage, and then in_stall rises.
// Reset (arst_n low) empties both stages, clears all clocks and the tick
// count, and sets both registers and the budget to 100000. The user must
// write registers via wr_en, wr_index, wr_data only while the block is idle (unenforced).
// ----------------------------------------------------------------------------
module tick_accumulating_system_clock_core import tasc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [INC_W-1:0]     wr_data
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic       can_load;
	logic       fire;
	out_item_t  result;
	cfg_write_t cfg;

	assign cfg.wr_en    = wr_en;
	assign cfg.wr_index = wr_index;
	assign cfg.wr_data  = wr_data;

	// An item in the input stage is processed when the output register can
	// take its result.
	assign fire = valid_s1 & can_load;

	tasc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.advance  (can_load),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tasc_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	tasc_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.result    (result),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	// A stall on the input only happens while an item is held in the stage.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input stage");

	// Every processed item shows up as a result in the next cycle.
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("processed item produced no result");

	// A read leaves system time alone and never crosses a tick boundary.
	a_read_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.kind != KIND_TICK && item_s1.kind != KIND_SET) |=>
		(out_data.system_time == out_data.old_time && !out_data.tick_elapsed))
		else $error("read item changed system time");

	// A set item reports the requested time as the new system time.
	a_set_takes_time: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.kind == KIND_SET) |=>
		(out_data.system_time == $past(item_s1.new_time) && !out_data.tick_elapsed))
		else $error("set item did not load the new system time");
`endif

endmodule
